>>> hdl/spa_pkg.sv
// package with shared types and constants of the sparse polynomial adder
package spa_pkg;

  // store sizing
  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);

  // field widths
  localparam int COEFF_W = 16;
  localparam int POWER_W = 16;
  localparam int SUM_W   = COEFF_W + 1;
  localparam int KIND_W  = 2;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

  // command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified operation
  typedef enum logic [1:0] {
    OP_LOAD_FIRST,
    OP_LOAD_SECOND,
    OP_START
  } spa_op_e;

  // merge engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } spa_state_e;

  // command passed from front to back
  typedef struct packed {
    spa_op_e                    op;
    logic signed [COEFF_W-1:0]  coeff;
    logic        [POWER_W-1:0]  power;
  } spa_cmd_t;

endpackage

>>> hdl/spa_if.sv
// stream interfaces for term requests and result requests

interface spa_term_if;
  logic                                 valid;
  logic                                 ready;
  logic [spa_pkg::KIND_W-1:0]           kind;
  logic signed [spa_pkg::COEFF_W-1:0]   term_coeff;
  logic [spa_pkg::POWER_W-1:0]          term_power;

  modport source (output valid, output kind, output term_coeff, output term_power,
                  input ready);
  modport sink   (input valid, input kind, input term_coeff, input term_power,
                  output ready);
endinterface

interface spa_sum_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spa_pkg::SUM_W-1:0]     sum_coeff;
  logic [spa_pkg::POWER_W-1:0]          sum_power;
  logic                                 last_term;
  logic                                 empty_sum;
  logic                                 overflowed;

  modport source (output valid, output sum_coeff, output sum_power, output last_term,
                  output empty_sum, output overflowed, input ready);
  modport sink   (input valid, input sum_coeff, input sum_power, input last_term,
                  input empty_sum, input overflowed, output ready);
endinterface

>>> hdl/sparse_polynomial_adder_top.sv
// Sparse polynomial adder top level. Term requests (kind 0 or 1) append one
// term to the first or second store of up to 32 terms; a start request (kind
// 2) merges both stores in descending power and streams the result terms,
// the final one marked last, or a single empty result when nothing remains.
// The merge engine takes loads only while it is idle. A merge runs each store
// step as a registered store read followed by a compare and sum, and it
// stalls when the result register is not taken. A four-deep request queue in
// front lets loads keep arriving while a merge is running. A term sent to a
// full store is dropped and the overflow flag shows on every result of the
// next merge.
module sparse_polynomial_adder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  spa_term_if.sink   term_i,
  spa_sum_if.source  sum_o
);

  logic              cmd_valid;
  logic              cmd_pop;
  spa_pkg::spa_cmd_t cmd;

  // request classification and queue
  spa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .term_i      (term_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // stores and merge engine
  spa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .sum_o       (sum_o)
  );

endmodule

>>> hdl/spa_front.sv
// front end: classifies incoming requests and queues them for the merge engine
module spa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  spa_term_if.sink          term_i,
  output logic              cmd_valid_o,
  output spa_pkg::spa_cmd_t cmd_o,
  input  logic              cmd_pop_i
);

  spa_pkg::spa_cmd_t                 queue_q [spa_pkg::QUEUE_DEPTH];
  logic [spa_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [spa_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [spa_pkg::QCNT_W-1:0]        fill_q, fill_d;
  logic                              accept;
  logic                              push;
  logic                              pop;
  spa_pkg::spa_cmd_t                 cmd_new;
  logic                              cmd_known;

  // classify the incoming kind, unused codes are swallowed
  always_comb begin
    cmd_new.coeff = term_i.term_coeff;
    cmd_new.power = term_i.term_power;
    cmd_new.op    = spa_pkg::OP_START;
    cmd_known     = 1'b1;
    case (term_i.kind)
      spa_pkg::KIND_FIRST:  cmd_new.op = spa_pkg::OP_LOAD_FIRST;
      spa_pkg::KIND_SECOND: cmd_new.op = spa_pkg::OP_LOAD_SECOND;
      spa_pkg::KIND_START:  cmd_new.op = spa_pkg::OP_START;
      default:              cmd_known  = 1'b0;
    endcase
  end

  // queue handshake
  assign term_i.ready = (fill_q != spa_pkg::QCNT_W'(spa_pkg::QUEUE_DEPTH));
  assign accept       = term_i.valid && term_i.ready;
  assign push         = accept && cmd_known;
  assign cmd_valid_o  = (fill_q != '0);
  assign pop          = cmd_pop_i && cmd_valid_o;
  assign cmd_o        = queue_q[rd_ptr_q];

  // pointer and fill updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> hdl/spa_back.sv
// back end: term stores and the merge engine that streams result terms
module spa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  spa_pkg::spa_cmd_t cmd_i,
  output logic              cmd_pop_o,
  spa_sum_if.source         sum_o
);

  localparam int ENTRY_W = spa_pkg::COEFF_W + spa_pkg::POWER_W;

  logic [ENTRY_W-1:0]                first_mem  [spa_pkg::MAX_TERMS];
  logic [ENTRY_W-1:0]                second_mem [spa_pkg::MAX_TERMS];
  logic [ENTRY_W-1:0]                rd_a_q, rd_b_q;

  spa_pkg::spa_state_e               state_q, state_d;
  logic [spa_pkg::CNT_W-1:0]         cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [spa_pkg::CNT_W-1:0]         i_q, i_d, j_q, j_d;
  logic                              drop_q, drop_d;
  logic                              hold_valid_q, hold_valid_d;
  logic signed [spa_pkg::SUM_W-1:0]  hold_coeff_q, hold_coeff_d;
  logic [spa_pkg::POWER_W-1:0]       hold_power_q, hold_power_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [spa_pkg::SUM_W-1:0]  out_coeff_q, out_coeff_d;
  logic [spa_pkg::POWER_W-1:0]       out_power_q, out_power_d;
  logic                              out_last_q, out_last_d;
  logic                              out_empty_q, out_empty_d;
  logic                              out_ovf_q, out_ovf_d;

  logic                              we_a, we_b;
  logic                              out_free;
  logic                              a_has, b_has;
  logic signed [spa_pkg::SUM_W-1:0]  coeff_a, coeff_b, coeff_sum;
  logic [spa_pkg::POWER_W-1:0]       power_a, power_b;
  logic signed [spa_pkg::SUM_W-1:0]  cand_coeff;
  logic [spa_pkg::POWER_W-1:0]       cand_power;
  logic                              cand_ok;
  logic                              step_a, step_b;

  // unpack the registered store reads
  assign coeff_a   = {rd_a_q[spa_pkg::COEFF_W-1], rd_a_q[spa_pkg::COEFF_W-1:0]};
  assign coeff_b   = {rd_b_q[spa_pkg::COEFF_W-1], rd_b_q[spa_pkg::COEFF_W-1:0]};
  assign power_a   = rd_a_q[ENTRY_W-1:spa_pkg::COEFF_W];
  assign power_b   = rd_b_q[ENTRY_W-1:spa_pkg::COEFF_W];
  assign coeff_sum = coeff_a + coeff_b;
  assign a_has     = (i_q < cnt_a_q);
  assign b_has     = (j_q < cnt_b_q);
  assign out_free  = !out_valid_q || sum_o.ready;

  // pick the next merge candidate
  always_comb begin
    cand_coeff = coeff_a;
    cand_power = power_a;
    cand_ok    = 1'b1;
    step_a     = 1'b0;
    step_b     = 1'b0;
    if (a_has && b_has) begin
      if (power_a == power_b) begin
        cand_coeff = coeff_sum;
        cand_ok    = (coeff_sum != '0);
        step_a     = 1'b1;
        step_b     = 1'b1;
      end else if (power_a > power_b) begin
        step_a = 1'b1;
      end else begin
        cand_coeff = coeff_b;
        cand_power = power_b;
        step_b     = 1'b1;
      end
    end else if (a_has) begin
      step_a = 1'b1;
    end else begin
      cand_coeff = coeff_b;
      cand_power = power_b;
      step_b     = 1'b1;
    end
  end

  // next state and outputs of the merge engine
  always_comb begin
    state_d      = state_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    i_d          = i_q;
    j_d          = j_q;
    drop_d       = drop_q;
    hold_valid_d = hold_valid_q;
    hold_coeff_d = hold_coeff_q;
    hold_power_d = hold_power_q;
    out_valid_d  = out_valid_q && !sum_o.ready;
    out_coeff_d  = out_coeff_q;
    out_power_d  = out_power_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_ovf_d    = out_ovf_q;
    cmd_pop_o    = 1'b0;
    we_a         = 1'b0;
    we_b         = 1'b0;
    case (state_q)
      spa_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            spa_pkg::OP_LOAD_FIRST: begin
              if (cnt_a_q < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
            spa_pkg::OP_LOAD_SECOND: begin
              if (cnt_b_q < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + 1'b1;
              end else begin
                drop_d = 1'b1;
              end
            end
            spa_pkg::OP_START: begin
              i_d          = '0;
              j_d          = '0;
              hold_valid_d = 1'b0;
              state_d      = spa_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      spa_pkg::ST_READ: begin
        state_d = spa_pkg::ST_EVAL;
      end
      spa_pkg::ST_EVAL: begin
        if (!a_has && !b_has) begin
          state_d = spa_pkg::ST_FLUSH;
        end else if (!(cand_ok && hold_valid_q && !out_free)) begin
          if (step_a) begin
            i_d = i_q + 1'b1;
          end
          if (step_b) begin
            j_d = j_q + 1'b1;
          end
          if (cand_ok) begin
            // the held term is known not to be last once another one appears
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_coeff_d = hold_coeff_q;
              out_power_d = hold_power_q;
              out_last_d  = 1'b0;
              out_empty_d = 1'b0;
              out_ovf_d   = drop_q;
            end
            hold_valid_d = 1'b1;
            hold_coeff_d = cand_coeff;
            hold_power_d = cand_power;
          end
          state_d = spa_pkg::ST_READ;
        end
      end
      spa_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_ovf_d    = drop_q;
          out_empty_d  = !hold_valid_q;
          out_coeff_d  = hold_valid_q ? hold_coeff_q : '0;
          out_power_d  = hold_valid_q ? hold_power_q : '0;
          hold_valid_d = 1'b0;
          cnt_a_d      = '0;
          cnt_b_d      = '0;
          drop_d       = 1'b0;
          state_d      = spa_pkg::ST_IDLE;
        end
      end
      default: state_d = spa_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spa_pkg::ST_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      drop_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      i_q          <= i_d;
      j_q          <= j_d;
      drop_q       <= drop_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_coeff_q <= hold_coeff_d;
    hold_power_q <= hold_power_d;
    out_coeff_q  <= out_coeff_d;
    out_power_q  <= out_power_d;
    out_last_q   <= out_last_d;
    out_empty_q  <= out_empty_d;
    out_ovf_q    <= out_ovf_d;
  end

  // term stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      first_mem[cnt_a_q[spa_pkg::IDX_W-1:0]] <= {cmd_i.power, cmd_i.coeff};
    end
    if (we_b) begin
      second_mem[cnt_b_q[spa_pkg::IDX_W-1:0]] <= {cmd_i.power, cmd_i.coeff};
    end
    rd_a_q <= first_mem[i_q[spa_pkg::IDX_W-1:0]];
    rd_b_q <= second_mem[j_q[spa_pkg::IDX_W-1:0]];
  end

  // result channel
  assign sum_o.valid      = out_valid_q;
  assign sum_o.sum_coeff  = out_coeff_q;
  assign sum_o.sum_power  = out_power_q;
  assign sum_o.last_term  = out_last_q;
  assign sum_o.empty_sum  = out_empty_q;
  assign sum_o.overflowed = out_ovf_q;

endmodule
